### hw/rtl/lzss_ring_decompressor_assert.svh
// Assertion macros for the decompressor RTL.
// No dependencies; included by the top level, which checks its command queue handshake.
`ifndef LZSS_RING_DECOMPRESSOR_ASSERT_SVH
`define LZSS_RING_DECOMPRESSOR_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define LZSD_ASSERT_IMP(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("lzsd check failed");

// Next-cycle implication, checked out of reset.
`define LZSD_ASSERT_NXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("lzsd check failed");

`endif

### hw/rtl/lzsd_pkg.sv
// Shared types and constants of the LZSS ring decompressor.
// No dependencies; imported by the command queue, front end, back end and top level.
package lzsd_pkg;

  localparam int RING_DEPTH = 4096;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam logic [RING_AW-1:0] PTR_START = 12'hFEE;
  localparam logic [15:0] FLAG_FILL = 16'hFF00;
  localparam int CNT_W      = 5;   // copy length 1..18
  localparam logic [CNT_W-1:0] MIN_MATCH = 5'd3;
  localparam int QDEPTH     = 4;
  localparam int QAW        = $clog2(QDEPTH);

  typedef enum logic [2:0] {
    PH_HDR0   = 3'd0,
    PH_HDR1   = 3'd1,
    PH_HDR2   = 3'd2,
    PH_HDR3   = 3'd3,
    PH_TOKEN  = 3'd4,
    PH_MATCH2 = 3'd5,
    PH_DONE   = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_LIT   = 2'd1,
    CMD_COPY  = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e          kind;
    logic [7:0]         lit;
    logic [RING_AW-1:0] src;
    logic [CNT_W-1:0]   cnt;
    logic               done;  // command ends the stream
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } cmdq_stat_t;

endpackage

### hw/rtl/lzsd_chan_if.sv
// Valid/ready channel interfaces for compressed input and decompressed output.
// Depends on nothing; used by the front end, back end and top level.
interface lzsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       stream_start;

  modport source (output valid, output in_byte, output stream_start, input ready);
  modport sink   (input valid, input in_byte, input stream_start, output ready);
endinterface

interface lzsd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       stream_done;

  modport source (output valid, output out_byte, output run_last, output stream_done,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input stream_done,
                  output ready);
endinterface

### hw/rtl/lzsd_ram.sv
// Generic single-clock RAM, one write and one read port, registered read-first data.
// No dependencies.
module lzsd_ram #(
  parameter int Width = 8,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/lzsd_cmdq.sv
// Short command queue between the parser front end and the copy back end.
// Depends on lzsd_pkg.
module lzsd_cmdq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  lzsd_pkg::cmd_t      cmd_i,
  input  logic                pop_i,
  output lzsd_pkg::cmd_t      head_o,
  output lzsd_pkg::cmdq_stat_t stat_o
);
  import lzsd_pkg::*;

  cmd_t           slot_q [QDEPTH];
  logic [QAW-1:0] wptr_q, wptr_d;
  logic [QAW-1:0] rptr_q, rptr_d;
  logic [QAW:0]   cnt_q, cnt_d;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= cmd_i;
    end
  end

  assign head_o       = slot_q[rptr_q];
  assign stat_o.full  = (cnt_q == (QAW+1)'(QDEPTH));
  assign stat_o.empty = (cnt_q == '0);

endmodule

### hw/rtl/lzsd_front.sv
// Front end: takes stream beats, tracks header, flags and output budget, emits commands.
// Depends on lzsd_pkg and lzsd_chan_if.
module lzsd_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  lzsd_in_if.sink              in_ch_i,
  input  lzsd_pkg::cmdq_stat_t cmdq_st_i,
  output logic                 push_o,
  output lzsd_pkg::cmd_t       cmd_o
);
  import lzsd_pkg::*;

  phase_e      phase_q, phase_d;
  logic [31:0] decl_q, decl_d;
  logic [31:0] prod_q, prod_d;
  logic [15:0] flag_q, flag_d;
  logic [7:0]  hold_q, hold_d;

  logic        acc, start;
  logic [7:0]  b;
  phase_e      eph;
  logic [31:0] edecl, eprod, remain, decl_shift;
  logic [15:0] eflag;
  logic [7:0]  ehold;
  logic [CNT_W-1:0] mlen, ecnt;
  logic        flag_empty, lit_done, copy_done;

  assign in_ch_i.ready = !cmdq_st_i.full;
  assign acc   = in_ch_i.valid && in_ch_i.ready;
  assign start = in_ch_i.stream_start;
  assign b     = in_ch_i.in_byte;

  // A start beat sees freshly cleared state and counts as header byte zero.
  assign eph   = start ? PH_HDR0 : phase_q;
  assign edecl = start ? '0 : decl_q;
  assign eprod = start ? '0 : prod_q;
  assign eflag = start ? '0 : flag_q;
  assign ehold = start ? '0 : hold_q;

  assign decl_shift = {edecl[23:0], b};
  assign remain     = edecl - eprod;  // nonzero while tokens are parsed
  assign mlen       = {1'b0, b[3:0]} + MIN_MATCH;
  assign copy_done  = (remain[31:CNT_W] == '0) && (remain[CNT_W-1:0] <= mlen);
  assign ecnt       = copy_done ? remain[CNT_W-1:0] : mlen;
  assign lit_done   = (remain == 32'd1);
  assign flag_empty = (eflag[15:8] == 8'h00);

  // next state
  always_comb begin
    phase_d = phase_q;
    if (acc) begin
      unique case (eph)
        PH_HDR0:   phase_d = PH_HDR1;
        PH_HDR1:   phase_d = PH_HDR2;
        PH_HDR2:   phase_d = PH_HDR3;
        PH_HDR3:   phase_d = (decl_shift == '0) ? PH_DONE : PH_TOKEN;
        PH_TOKEN: begin
          if (flag_empty) begin
            phase_d = PH_TOKEN;
          end else if (eflag[0]) begin
            phase_d = lit_done ? PH_DONE : PH_TOKEN;
          end else begin
            phase_d = PH_MATCH2;
          end
        end
        PH_MATCH2: phase_d = copy_done ? PH_DONE : PH_TOKEN;
        PH_DONE:   phase_d = PH_DONE;
        default:   phase_d = PH_DONE;
      endcase
    end
  end

  // datapath and command output
  always_comb begin
    decl_d      = decl_q;
    prod_d      = prod_q;
    flag_d      = flag_q;
    hold_d      = hold_q;
    push_o      = 1'b0;
    cmd_o.kind  = CMD_START;
    cmd_o.lit   = b;
    cmd_o.src   = {b[7:4], ehold};
    cmd_o.cnt   = ecnt;
    cmd_o.done  = 1'b0;
    if (acc) begin
      decl_d = edecl;
      prod_d = eprod;
      flag_d = eflag;
      hold_d = ehold;
      push_o = start;
      unique case (eph)
        PH_HDR0, PH_HDR1, PH_HDR2, PH_HDR3: begin
          decl_d = decl_shift;
        end
        PH_TOKEN: begin
          if (flag_empty) begin
            flag_d = {8'h00, b} | FLAG_FILL;
          end else if (eflag[0]) begin
            push_o     = 1'b1;
            cmd_o.kind = CMD_LIT;
            cmd_o.done = lit_done;
            prod_d     = eprod + 32'd1;
            flag_d     = eflag >> 1;
          end else begin
            hold_d = b;
          end
        end
        PH_MATCH2: begin
          push_o     = 1'b1;
          cmd_o.kind = CMD_COPY;
          cmd_o.done = copy_done;
          prod_d     = eprod + {{(32-CNT_W){1'b0}}, ecnt};
          flag_d     = eflag >> 1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HDR0;
      decl_q  <= '0;
      prod_q  <= '0;
      flag_q  <= '0;
      hold_q  <= '0;
    end else begin
      phase_q <= phase_d;
      decl_q  <= decl_d;
      prod_q  <= prod_d;
      flag_q  <= flag_d;
      hold_q  <= hold_d;
    end
  end

endmodule

### hw/rtl/lzsd_back.sv
// Back end: runs literal and copy commands on the ring, a byte a cycle unless stalled.
// Depends on lzsd_pkg, lzsd_chan_if and lzsd_ram.
module lzsd_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lzsd_pkg::cmd_t       head_i,
  input  lzsd_pkg::cmdq_stat_t cmdq_st_i,
  output logic                 pop_o,
  lzsd_out_if.source           out_ch_o
);
  import lzsd_pkg::*;

  logic [CNT_W-1:0]   idx_q, idx_d;
  logic [RING_AW-1:0] wptr_q, wptr_d;
  logic [RING_AW:0]   fill_q, fill_d;   // bytes written this stream, saturates at depth

  // read stage
  logic       s1_v_q, s1_start_q, s1_last_q, s1_done_q;
  logic       s1_hold_q, s1_ok_q;
  logic [7:0] s1_held_q;

  logic       out_v_q;
  logic [7:0] out_byte_q;
  logic       out_last_q, out_done_q;

  logic               adv, issue, last_elem, s1_data, wr_en, hit, fill_ok, mem_ok;
  logic [RING_AW-1:0] rd_addr, ofs;
  logic [7:0]         rd_data, s1_byte;

  assign adv       = !out_v_q || out_ch_o.ready;
  assign issue     = adv && !cmdq_st_i.empty;
  assign last_elem = (head_i.kind != CMD_COPY) || ((idx_q + 1'b1) == head_i.cnt);
  assign pop_o     = issue && last_elem;
  assign idx_d     = issue ? (last_elem ? '0 : idx_q + 1'b1) : idx_q;

  assign rd_addr = head_i.src + {{(RING_AW-CNT_W){1'b0}}, idx_q};
  assign s1_data = s1_v_q && !s1_start_q;
  assign wr_en   = adv && s1_data;

  // Entries not yet written this stream read as zero; writes run contiguously
  // from the start pointer, so the fill count tells which ones exist.
  assign ofs     = rd_addr - PTR_START;
  assign fill_ok = fill_q[RING_AW] || (ofs < fill_q[RING_AW-1:0]);
  assign mem_ok  = fill_ok && !(s1_v_q && s1_start_q);
  // RAM reads old data when the byte in flight lands on the same address
  assign hit     = wr_en && (rd_addr == wptr_q);

  assign s1_byte = s1_hold_q ? s1_held_q : (s1_ok_q ? rd_data : 8'h00);

  lzsd_ram #(
    .Width (8),
    .Depth (RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wptr_q),
    .wdata_i (s1_byte),
    .re_i    (issue && (head_i.kind == CMD_COPY)),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  always_comb begin
    wptr_d = wptr_q;
    fill_d = fill_q;
    if (adv && s1_v_q && s1_start_q) begin
      wptr_d = PTR_START;
      fill_d = '0;
    end else if (wr_en) begin
      wptr_d = wptr_q + 1'b1;
      fill_d = fill_q[RING_AW] ? fill_q : fill_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      wptr_q  <= PTR_START;
      fill_q  <= '0;
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      idx_q  <= idx_d;
      wptr_q <= wptr_d;
      fill_q <= fill_d;
      if (adv) begin
        s1_v_q  <= issue;
        out_v_q <= s1_data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_start_q <= (head_i.kind == CMD_START);
      s1_last_q  <= last_elem;
      s1_done_q  <= head_i.done && last_elem;
      s1_hold_q  <= (head_i.kind == CMD_LIT) || hit;
      s1_held_q  <= (head_i.kind == CMD_LIT) ? head_i.lit : s1_byte;
      s1_ok_q    <= mem_ok;
      out_byte_q <= s1_byte;
      out_last_q <= s1_last_q;
      out_done_q <= s1_done_q;
    end
  end

  assign out_ch_o.valid       = out_v_q;
  assign out_ch_o.out_byte    = out_byte_q;
  assign out_ch_o.run_last    = out_last_q;
  assign out_ch_o.stream_done = out_done_q;

endmodule

### hw/rtl/lzss_ring_decompressor.sv
// LZSS decompressor with a 4 KiB history ring: top level.
// Depends on lzsd_pkg, lzsd_chan_if, lzsd_front, lzsd_cmdq, lzsd_back and the assert header.
//
// in_ch_i carries one compressed byte per beat; stream_start marks the first
// header byte of a stream. out_ch_o carries one decompressed byte per beat,
// with run_last on the last byte caused by an input beat and stream_done on
// the byte that reaches the declared length.
// Header, flag and first-match bytes are parsed and give no output. A
// literal passes through the command queue, the read stage and the output
// register after its beat is accepted. A match issues 1..18 ring reads, one
// per cycle while the receiver is ready, so the back end sustains one output
// byte per clock. The four-entry command queue lets input run ahead until it
// fills, then in_ch_i.ready drops.
// The ring needs no clearing pass: a per-stream fill count makes never
// written entries read as zero. Reset returns the parser to header byte
// zero and empties the queue and output register.
// When the receiver stalls, the output beat holds and the back end freezes,
// ring reads included; the front keeps parsing until the queue is full.
module lzss_ring_decompressor (
  input  logic        clk_i,
  input  logic        rst_ni,
  lzsd_in_if.sink     in_ch_i,
  lzsd_out_if.source  out_ch_o
);
  import lzsd_pkg::*;

  `include "lzss_ring_decompressor_assert.svh"

  logic       cmd_push, cmd_pop;
  cmd_t       cmd_data, cmd_head;
  cmdq_stat_t cmdq_st;
  logic       in_start_beat;

  assign in_start_beat = in_ch_i.valid && in_ch_i.ready && in_ch_i.stream_start;

  lzsd_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_ch_i   (in_ch_i),
    .cmdq_st_i (cmdq_st),
    .push_o    (cmd_push),
    .cmd_o     (cmd_data)
  );

  lzsd_cmdq u_cmdq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .cmd_i  (cmd_data),
    .pop_i  (cmd_pop),
    .head_o (cmd_head),
    .stat_o (cmdq_st)
  );

  lzsd_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .head_i    (cmd_head),
    .cmdq_st_i (cmdq_st),
    .pop_o     (cmd_pop),
    .out_ch_o  (out_ch_o)
  );

  `LZSD_ASSERT_IMP(a_no_push_full, clk_i, rst_ni, cmd_push, !cmdq_st.full)
  `LZSD_ASSERT_IMP(a_no_pop_empty, clk_i, rst_ni, cmd_pop, !cmdq_st.empty)
  `LZSD_ASSERT_IMP(a_start_cmd, clk_i, rst_ni, in_start_beat, cmd_push && (cmd_data.kind == CMD_START))

endmodule
